FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/pdt_pkg.sv
// Types, constants and the delta table of the prefetch degree throttle.
`timescale 1ns / 1ps

package pdt_pkg;

   localparam int TICK_W  = 24;
   localparam int COUNT_W = 32;
   localparam int DEG_W   = 4;
   localparam int BW_W    = 4;
   localparam int CNT_W   = 4;
   localparam int CSR_W   = 24;

   // Reset values of the configuration registers
   localparam logic [TICK_W-1:0] EPOCH_LENGTH_RESET = 24'd4096;
   localparam logic [DEG_W-1:0]  MAX_DEGREE_RESET   = 4'd4;
   localparam logic [DEG_W-1:0]  MIN_DEGREE_RESET   = 4'd1;

   // Bandwidth level thresholds: (level*100)/16 >= 90 and >= 25
   localparam logic [BW_W-1:0] BW_HIGH_LEVEL = 4'd15;
   localparam logic [BW_W-1:0] BW_MID_LEVEL  = 4'd4;

   typedef enum logic [1:0] {
      CSR_EPOCH_LENGTH = 2'd0,
      CSR_MAX_DEGREE   = 2'd1,
      CSR_MIN_DEGREE   = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_TICK   = 1'b0,
      REQ_ACCESS = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CLASS_HIGH = 2'd0,
      CLASS_MID  = 2'd1,
      CLASS_LOW  = 2'd2
   } class_type;

   typedef struct packed {
      logic [TICK_W-1:0] epoch_length;
      logic [DEG_W-1:0]  max_degree;
      logic [DEG_W-1:0]  min_degree;
   } cfg_type;

   // Degree delta by bandwidth class (row) and accuracy class (column)
   function automatic logic signed [2:0] delta_lookup(class_type bw, class_type acc);
      logic signed [2:0] d;
      d = 3'sd0;
      case (bw)
         CLASS_HIGH: begin
            case (acc)
               CLASS_HIGH: d = 3'sd0;
               CLASS_MID:  d = -3'sd1;
               default:    d = -3'sd2;
            endcase
         end
         CLASS_MID: begin
            case (acc)
               CLASS_HIGH: d = 3'sd1;
               CLASS_MID:  d = 3'sd0;
               default:    d = -3'sd1;
            endcase
         end
         default: begin
            case (acc)
               CLASS_HIGH: d = 3'sd2;
               CLASS_MID:  d = 3'sd1;
               default:    d = 3'sd0;
            endcase
         end
      endcase
      return d;
   endfunction

endpackage

FILE: design/pdt_adapt.sv
// Epoch-end degree adaptation: accuracy and bandwidth classes, delta, clamp.
`timescale 1ns / 1ps

module pdt_adapt (
   input  logic [pdt_pkg::DEG_W-1:0]   cur_degree,
   input  pdt_pkg::cfg_type            cfg,
   input  logic [pdt_pkg::BW_W-1:0]    bw_level,
   input  logic [pdt_pkg::COUNT_W-1:0] issued_total,
   input  logic [pdt_pkg::COUNT_W-1:0] useful_total,
   output logic [pdt_pkg::DEG_W-1:0]   next_degree
);

   logic [pdt_pkg::COUNT_W+3:0] useful_x10;
   logic [pdt_pkg::COUNT_W+3:0] issued_x9;
   logic [pdt_pkg::COUNT_W:0]   useful_x2;
   pdt_pkg::class_type          acc_class;
   pdt_pkg::class_type          bw_class;
   logic signed [2:0]           delta;
   logic signed [5:0]           sum;
   logic signed [5:0]           lo_bound;
   logic signed [5:0]           hi_bound;
   logic signed [5:0]           clamped;

   // Accuracy: useful*100 >= issued*90 reduces to useful*10 >= issued*9,
   // useful*100 >= issued*50 to useful*2 >= issued
   always_comb begin
      useful_x10 = ({4'd0, useful_total} << 3) + ({4'd0, useful_total} << 1);
      issued_x9  = ({4'd0, issued_total} << 3) + {4'd0, issued_total};
      useful_x2  = {useful_total, 1'b0};
      if (issued_total == '0) begin
         acc_class = pdt_pkg::CLASS_LOW;
      end else if (useful_x10 >= issued_x9) begin
         acc_class = pdt_pkg::CLASS_HIGH;
      end else if (useful_x2 >= {1'b0, issued_total}) begin
         acc_class = pdt_pkg::CLASS_MID;
      end else begin
         acc_class = pdt_pkg::CLASS_LOW;
      end
   end

   // Bandwidth class from the sampled level
   always_comb begin
      if (bw_level >= pdt_pkg::BW_HIGH_LEVEL) begin
         bw_class = pdt_pkg::CLASS_HIGH;
      end else if (bw_level >= pdt_pkg::BW_MID_LEVEL) begin
         bw_class = pdt_pkg::CLASS_MID;
      end else begin
         bw_class = pdt_pkg::CLASS_LOW;
      end
   end

   // Apply delta, raise to min, then lower to max (max wins)
   always_comb begin
      delta    = pdt_pkg::delta_lookup(bw_class, acc_class);
      lo_bound = $signed({2'b00, cfg.min_degree});
      hi_bound = $signed({2'b00, cfg.max_degree});
      sum      = $signed({2'b00, cur_degree}) + $signed({{3{delta[2]}}, delta});
      clamped  = sum;
      if (clamped < lo_bound) begin
         clamped = lo_bound;
      end
      if (clamped > hi_bound) begin
         clamped = hi_bound;
      end
      if (clamped < 6'sd0) begin
         clamped = 6'sd0;
      end
      next_degree = clamped[pdt_pkg::DEG_W-1:0];
   end

endmodule

FILE: design/prefetch_degree_throttle_core.sv
// Top level of the prefetch degree throttle: counters, epoch logic, result buffer.
`timescale 1ns / 1ps
//
// Adapts a prefetch degree once per epoch from accuracy and bandwidth feedback.
// Request channel (req_*): req_tuser = 0 is a cycle tick, 1 an access report.
// Access reports add issued prefetches and a useful flag to saturating totals;
// ticks count toward epoch_length and the tick that reaches it closes the
// epoch, adapts the degree with the sampled bandwidth level and clears totals.
// Response channel (rsp_*): one response per request, the degree after the
// request and rsp_tlast set when that tick closed an epoch.
// Each accepted request's response is registered; one request is taken every cycle
// while req_tready is high, the whole update being a single registered pass.
// A two-entry output buffer (result register plus skid register) lets a new
// request in while a response waits; req_tready drops only when both hold
// responses, that is after the receiver stalls on a waiting
// response while another request arrives.
// Configuration (csr_*) writes: degree bounds apply at the next epoch end, epoch_length
// at the next tick; writes do not clamp the degree. Unknown indices are ignored.
// Synchronous reset restores register defaults, sets the degree to the reset
// maximum, clears counters and empties the output buffer.

`include "assert_macros.svh"

module prefetch_degree_throttle_core (
   input  logic                        clock,
   input  logic                        reset,
   // configuration write port
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [pdt_pkg::CSR_W-1:0]   csr_wdata,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,  // [3:0] issued_count, [4] useful_flag,
                                                   // [8:5] bw_level, [15:9] zero
   input  logic                        req_tuser,  // [0] req_type
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,  // [3:0] degree, [7:4] zero
   output logic                        rsp_tlast   // epoch_ended
);

   pdt_pkg::cfg_type                cfg_ff;
   logic [pdt_pkg::DEG_W-1:0]       cur_degree_ff;
   logic [pdt_pkg::TICK_W-1:0]      tick_count_ff;
   logic [pdt_pkg::COUNT_W-1:0]     issued_total_ff;
   logic [pdt_pkg::COUNT_W-1:0]     useful_total_ff;

   logic                            rsp_valid_ff;
   logic [pdt_pkg::DEG_W-1:0]       rsp_degree_ff;
   logic                            rsp_last_ff;
   logic                            skid_valid_ff;
   logic [pdt_pkg::DEG_W-1:0]       skid_degree_ff;
   logic                            skid_last_ff;

   logic [pdt_pkg::CNT_W-1:0]       req_issued;
   logic                            req_useful;
   logic [pdt_pkg::BW_W-1:0]        req_bw;
   logic                            is_access;
   logic                            push;
   logic                            pop;
   logic [pdt_pkg::TICK_W-1:0]      tick_next;
   logic                            epoch_end;
   logic [pdt_pkg::COUNT_W:0]       issued_sum;
   logic [pdt_pkg::COUNT_W:0]       useful_sum;
   logic [pdt_pkg::COUNT_W-1:0]     issued_in;
   logic [pdt_pkg::COUNT_W-1:0]     useful_in;
   logic [pdt_pkg::DEG_W-1:0]       adapted_degree;
   logic [pdt_pkg::DEG_W-1:0]       degree_in;

   // Request unpacking and handshakes
   assign req_issued = req_tdata[3:0];
   assign req_useful = req_tdata[4];
   assign req_bw     = req_tdata[8:5];
   assign is_access  = (req_tuser == pdt_pkg::REQ_ACCESS);
   assign req_tready = !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = rsp_valid_ff && rsp_tready;

   // Epoch counter and saturating totals
   always_comb begin
      tick_next  = tick_count_ff + {{(pdt_pkg::TICK_W-1){1'b0}}, 1'b1};
      epoch_end  = !is_access && (tick_next >= cfg_ff.epoch_length);
      issued_sum = {1'b0, issued_total_ff} + {{(pdt_pkg::COUNT_W-pdt_pkg::CNT_W+1){1'b0}},
                                               req_issued};
      useful_sum = {1'b0, useful_total_ff} + {{pdt_pkg::COUNT_W{1'b0}}, req_useful};
      issued_in  = issued_sum[pdt_pkg::COUNT_W] ? '1 : issued_sum[pdt_pkg::COUNT_W-1:0];
      useful_in  = useful_sum[pdt_pkg::COUNT_W] ? '1 : useful_sum[pdt_pkg::COUNT_W-1:0];
      degree_in  = epoch_end ? adapted_degree : cur_degree_ff;
   end

   pdt_adapt u_adapt (
      .cur_degree   (cur_degree_ff),
      .cfg          (cfg_ff),
      .bw_level     (req_bw),
      .issued_total (issued_total_ff),
      .useful_total (useful_total_ff),
      .next_degree  (adapted_degree)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.epoch_length <= pdt_pkg::EPOCH_LENGTH_RESET;
         cfg_ff.max_degree   <= pdt_pkg::MAX_DEGREE_RESET;
         cfg_ff.min_degree   <= pdt_pkg::MIN_DEGREE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pdt_pkg::CSR_EPOCH_LENGTH: cfg_ff.epoch_length <= csr_wdata;
            pdt_pkg::CSR_MAX_DEGREE:   cfg_ff.max_degree   <= csr_wdata[pdt_pkg::DEG_W-1:0];
            pdt_pkg::CSR_MIN_DEGREE:   cfg_ff.min_degree   <= csr_wdata[pdt_pkg::DEG_W-1:0];
            default: ;
         endcase
      end
   end

   // Throttle state, updated once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_degree_ff   <= pdt_pkg::MAX_DEGREE_RESET;
         tick_count_ff   <= '0;
         issued_total_ff <= '0;
         useful_total_ff <= '0;
      end else if (push) begin
         cur_degree_ff <= degree_in;
         if (is_access) begin
            issued_total_ff <= issued_in;
            useful_total_ff <= useful_in;
         end else if (epoch_end) begin
            tick_count_ff   <= '0;
            issued_total_ff <= '0;
            useful_total_ff <= '0;
         end else begin
            tick_count_ff <= tick_next;
         end
      end
   end

   // Output buffer control: result register refills from skid first
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Output buffer payload
   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_degree_ff <= skid_degree_ff;
            rsp_last_ff   <= skid_last_ff;
         end else if (push) begin
            rsp_degree_ff <= degree_in;
            rsp_last_ff   <= epoch_end;
         end
      end else if (push) begin
         skid_degree_ff <= degree_in;
         skid_last_ff   <= epoch_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_degree_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `ASSERT_IMPLIES(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff,
                   "skid holds a response while the result register is empty")
   `ASSERT_IMPLIES(a_epoch_degree_max, clock, reset, rsp_valid_ff && rsp_last_ff,
                   rsp_degree_ff <= cfg_ff.max_degree,
                   "adapted degree above the configured maximum")
   `ASSERT_NEXT(a_access_keeps_ticks, clock, reset, push && is_access,
                $stable(tick_count_ff) && $stable(cur_degree_ff),
                "access report changed tick count or degree")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench of the prefetch degree throttle core.
`timescale 1ns / 1ps

module testbench;

   // Run shape
   localparam int RANDOM_ITEMS  = 1900;
   localparam int HOLD_CYCLES   = 300;   // long receiver stall, fills the output buffer
   localparam int STALL_LIMIT   = 2000;  // several times the hold plus the longest gaps
   localparam int SETTLE_CYCLES = 3;     // margin after the last response
   localparam int END_CYCLES    = 10;

   // Index that decodes to no register
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      pdt_pkg::req_kind_type kind;
      logic [3:0]            issued;
      logic                  useful;
      logic [3:0]            bw_level;
   } req_item_type;

   typedef struct packed {
      logic [3:0] degree;
      logic       epoch_ended;
   } throttle_result_type;

   typedef enum logic {
      STEP_REQUEST,
      STEP_CSR
   } step_kind_type;

   typedef struct {
      step_kind_type       what;
      req_item_type        item;
      bit                  typed;
      throttle_result_type result;
      logic [1:0]          csr_idx;
      logic [23:0]         csr_val;
   } plan_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      csr_we     = 1'b0;
   logic [1:0]                csr_index  = '0;
   logic [pdt_pkg::CSR_W-1:0] csr_wdata  = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata  = '0;  // [3:0] issued_count, [4] useful_flag,
                                                // [8:5] bw_level
   logic                      req_tuser  = 1'b0; // [0] req_type
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;        // [3:0] degree
   logic                      rsp_tlast;

   // Predicted state of the block
   pdt_pkg::cfg_type model_cfg;
   logic [3:0]       model_degree;
   logic [23:0]      model_ticks;
   logic [31:0]      model_issued;
   logic [31:0]      model_useful;

   throttle_result_type expected_results[$];
   plan_step_type       plan_steps[$];

   int error_count = 0;
   int quiet_cycles = 0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;
   bit hold_off_request = 1'b0;

   prefetch_degree_throttle_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Degree and epoch flag after one request; updates the predicted state
   function automatic throttle_result_type predict_throttle(req_item_type item);
      logic [32:0]          sum;
      logic [23:0]          next_tick;
      logic [63:0]          hit_weight;
      pdt_pkg::class_type   acc_grade;
      pdt_pkg::class_type   bw_grade;
      int                   bw_pct;
      int                   level;
      throttle_result_type  res;
      res.epoch_ended = 1'b0;
      if (item.kind == pdt_pkg::REQ_ACCESS) begin
         // saturating totals
         sum = {1'b0, model_issued} + 33'(item.issued);
         model_issued = sum[32] ? '1 : sum[31:0];
         sum = {1'b0, model_useful} + 33'(item.useful);
         model_useful = sum[32] ? '1 : sum[31:0];
      end else begin
         next_tick = model_ticks + 24'd1;
         if (next_tick >= model_cfg.epoch_length) begin
            hit_weight = 64'(model_useful) * 64'd100;
            if (model_issued == 32'd0) begin
               acc_grade = pdt_pkg::CLASS_LOW;
            end else if (hit_weight >= 64'(model_issued) * 64'd90) begin
               acc_grade = pdt_pkg::CLASS_HIGH;
            end else if (hit_weight >= 64'(model_issued) * 64'd50) begin
               acc_grade = pdt_pkg::CLASS_MID;
            end else begin
               acc_grade = pdt_pkg::CLASS_LOW;
            end
            bw_pct = (int'(item.bw_level) * 100) / 16;
            if (bw_pct >= 90) begin
               bw_grade = pdt_pkg::CLASS_HIGH;
            end else if (bw_pct >= 25) begin
               bw_grade = pdt_pkg::CLASS_MID;
            end else begin
               bw_grade = pdt_pkg::CLASS_LOW;
            end
            // each step down in bandwidth adds one, each step down in accuracy removes one
            level = int'(model_degree) + int'(bw_grade) - int'(acc_grade);
            if (level < int'(model_cfg.min_degree)) level = int'(model_cfg.min_degree);
            if (level > int'(model_cfg.max_degree)) level = int'(model_cfg.max_degree);
            model_degree = level[3:0];
            model_ticks = '0;
            model_issued = '0;
            model_useful = '0;
            res.epoch_ended = 1'b1;
         end else begin
            model_ticks = next_tick;
         end
      end
      res.degree = model_degree;
      return res;
   endfunction

   task automatic plan_request(pdt_pkg::req_kind_type kind, logic [3:0] issued, logic useful,
                               logic [3:0] bw, bit typed = 1'b0, logic [3:0] degree = '0,
                               logic ended = 1'b0);
      plan_step_type s;
      s.what = STEP_REQUEST;
      s.item = '{kind, issued, useful, bw};
      s.typed = typed;
      s.result = '{degree, ended};
      s.csr_idx = '0;
      s.csr_val = '0;
      plan_steps.push_back(s);
   endtask

   task automatic plan_csr(logic [1:0] idx, logic [23:0] value);
      plan_step_type s;
      s.what = STEP_CSR;
      s.item = '0;
      s.typed = 1'b0;
      s.result = '0;
      s.csr_idx = idx;
      s.csr_val = value;
      plan_steps.push_back(s);
   endtask

   // Offer one request after a random gap; record its expectation on acceptance
   task automatic send_request(req_item_type item, bit typed,
                               throttle_result_type typed_result);
      int                  gap;
      throttle_result_type predicted;
      gap = tx_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item.kind;
      req_tdata  <= {7'd0, item.bw_level, item.useful, item.issued};
      do @(posedge clock); while (!req_tready);
      predicted = predict_throttle(item);
      expected_results.push_back(typed ? typed_result : predicted);
   endtask

   // Stop offering and wait until every response is back
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [23:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         pdt_pkg::CSR_EPOCH_LENGTH: model_cfg.epoch_length = value;
         pdt_pkg::CSR_MAX_DEGREE:   model_cfg.max_degree = value[3:0];
         pdt_pkg::CSR_MIN_DEGREE:   model_cfg.min_degree = value[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Receiver: random stalls, steady stretches, one long hold-off
   initial begin : receiver
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            stall = HOLD_CYCLES;
            hold_off_request = 1'b0;
         end else begin
            stall = rx_steady ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Response check against the oldest expectation
   always @(posedge clock) begin : check_responses
      throttle_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: response with none expected: degree %0d, epoch_ended %0d",
                     $time, rsp_tdata[3:0], rsp_tlast);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[3:0] !== want.degree) begin
               $display("%0t: degree expected %0d, actual %0d",
                        $time, want.degree, rsp_tdata[3:0]);
               error_count++;
            end
            if (rsp_tlast !== want.epoch_ended) begin
               $display("%0t: epoch_ended expected %0d, actual %0d",
                        $time, want.epoch_ended, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, nothing accepted for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      int           done_items;
      int           phase_index;
      int           phase_len;
      int           tick_pct;
      int           useful_pct;
      logic [23:0]  epoch_value;
      logic [3:0]   max_nib;
      logic [3:0]   min_nib;
      req_item_type item;

      model_cfg.epoch_length = pdt_pkg::EPOCH_LENGTH_RESET;
      model_cfg.max_degree   = pdt_pkg::MAX_DEGREE_RESET;
      model_cfg.min_degree   = pdt_pkg::MIN_DEGREE_RESET;
      model_degree = pdt_pkg::MAX_DEGREE_RESET;
      model_ticks  = '0;
      model_issued = '0;
      model_useful = '0;

      // Directed table: reset state, every accuracy and bandwidth class, clamps
      plan_request(pdt_pkg::REQ_ACCESS, 4'd15, 1'b1, 4'd0, 1'b1, 4'd4, 1'b0);  // reset degree
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd0, 1'b1, 4'd4, 1'b0);
      plan_csr(pdt_pkg::CSR_EPOCH_LENGTH, 24'd1);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd15, 1'b1, 4'd2, 1'b1);   // low acc, high bw
      plan_request(pdt_pkg::REQ_TICK, 4'd15, 1'b1, 4'd15, 1'b1, 4'd1, 1'b1);  // nothing issued
      plan_request(pdt_pkg::REQ_ACCESS, 4'd1, 1'b1, 4'd0, 1'b1, 4'd1, 1'b0);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd0, 1'b1, 4'd3, 1'b1);    // high acc, low bw
      plan_request(pdt_pkg::REQ_ACCESS, 4'd2, 1'b1, 4'd15);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd4);                      // mid edges
      plan_request(pdt_pkg::REQ_ACCESS, 4'd0, 1'b1, 4'd0);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd3);
      plan_request(pdt_pkg::REQ_ACCESS, 4'd1, 1'b1, 4'd0);
      plan_request(pdt_pkg::REQ_ACCESS, 4'd0, 1'b1, 4'd0);                    // useful above issued
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd14);
      plan_csr(pdt_pkg::CSR_MAX_DEGREE, 24'hFFFFFF);
      plan_csr(pdt_pkg::CSR_MIN_DEGREE, 24'hFFFFF0);
      plan_request(pdt_pkg::REQ_ACCESS, 4'd1, 1'b1, 4'd0);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd0, 1'b1, 4'd6, 1'b1);
      // min above max: max wins
      plan_csr(pdt_pkg::CSR_MIN_DEGREE, 24'h00000F);
      plan_csr(pdt_pkg::CSR_MAX_DEGREE, 24'h000001);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd15, 1'b1, 4'd1, 1'b1);
      plan_csr(pdt_pkg::CSR_MAX_DEGREE, 24'h00000F);
      plan_request(pdt_pkg::REQ_ACCESS, 4'd1, 1'b1, 4'd0);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd0, 1'b1, 4'd15, 1'b1);
      plan_request(pdt_pkg::REQ_ACCESS, 4'd1, 1'b1, 4'd0);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd0, 1'b1, 4'd15, 1'b1);   // top clamp
      // zero epoch length: every tick closes an epoch
      plan_csr(pdt_pkg::CSR_MIN_DEGREE, 24'd0);
      plan_csr(pdt_pkg::CSR_EPOCH_LENGTH, 24'd0);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd15, 1'b1, 4'd13, 1'b1);
      // longest epoch, then lowered below the running count
      plan_csr(pdt_pkg::CSR_EPOCH_LENGTH, 24'hFFFFFF);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd0, 1'b1, 4'd13, 1'b0);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd0, 1'b1, 4'd13, 1'b0);
      plan_csr(pdt_pkg::CSR_EPOCH_LENGTH, 24'd1);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd8);
      // write to an unknown index is ignored
      plan_csr(CSR_SPARE, 24'd0);
      plan_request(pdt_pkg::REQ_ACCESS, 4'd15, 1'b0, 4'd0, 1'b1, 4'd12, 1'b0);
      plan_request(pdt_pkg::REQ_TICK, 4'd0, 1'b0, 4'd15, 1'b1, 4'd10, 1'b1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan_steps[n]) begin
         if (plan_steps[n].what == STEP_CSR) begin
            settle_block();
            write_csr(plan_steps[n].csr_idx, plan_steps[n].csr_val);
         end else begin
            send_request(plan_steps[n].item, plan_steps[n].typed, plan_steps[n].result);
         end
      end

      // Random phases, each with its own settings and traffic mix
      done_items = 0;
      phase_index = 0;
      while (done_items < RANDOM_ITEMS) begin
         settle_block();
         case ($urandom_range(0, 9))
            0:       epoch_value = 24'd0;
            1:       epoch_value = 24'($urandom());
            2:       epoch_value = 24'($urandom_range(13, 64));
            default: epoch_value = 24'($urandom_range(1, 12));
         endcase
         write_csr(pdt_pkg::CSR_EPOCH_LENGTH, epoch_value);
         if ($urandom_range(0, 1) == 1) begin
            max_nib = 4'($urandom_range(1, 15));
            write_csr(pdt_pkg::CSR_MAX_DEGREE, {20'($urandom()), max_nib});
         end
         if ($urandom_range(0, 1) == 1) begin
            if ($urandom_range(0, 3) == 0) begin
               min_nib = 4'($urandom_range(0, 15));
            end else begin
               min_nib = 4'($urandom_range(0, int'(model_cfg.max_degree)));
            end
            write_csr(pdt_pkg::CSR_MIN_DEGREE, {20'($urandom()), min_nib});
         end
         if ($urandom_range(0, 15) == 0) begin
            write_csr(CSR_SPARE, 24'($urandom()));
         end

         tick_pct   = $urandom_range(20, 80);
         useful_pct = $urandom_range(0, 100);
         tx_steady  = ($urandom_range(0, 3) == 0);
         rx_steady  = ($urandom_range(0, 3) == 0);
         if (phase_index == 2) begin
            // receiver holds off while the sender keeps offering
            tx_steady = 1'b1;
            rx_steady = 1'b0;
            hold_off_request = 1'b1;
         end

         phase_len = $urandom_range(60, 200);
         for (int i = 0; i < phase_len; i++) begin
            item.kind     = ($urandom_range(0, 99) < tick_pct) ? pdt_pkg::REQ_TICK
                                                                : pdt_pkg::REQ_ACCESS;
            item.issued   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(0, 3));
            item.useful   = ($urandom_range(0, 99) < useful_pct);
            item.bw_level = 4'($urandom_range(0, 15));
            send_request(item, 1'b0, '0);
            done_items++;
         end
         phase_index++;
      end

      settle_block();
      repeat (END_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/pdt_pkg.sv
design/pdt_adapt.sv
design/prefetch_degree_throttle_core.sv
verif/testbench.sv
